[sv/mwe_pkg.sv]
// Shared types, constants and helper functions for the Microwire EEPROM pin interface.
// Used by mwe_ctrl, mwe_datapath and the top level; depends on nothing else.
`default_nettype none

package mwe_pkg;

  // Store geometry.
  localparam int EEPROM_WORDS = 128;
  localparam int ADDR_W       = $clog2(EEPROM_WORDS);
  localparam int WORD_W       = 16;

  // Protocol state codes.
  localparam logic [4:0] ST_IDLE  = 5'h00;
  localparam logic [4:0] ST_CMD   = 5'h01;
  localparam logic [4:0] ST_DOUT  = 5'h02;
  localparam logic [4:0] ST_EWDS  = 5'h10;
  localparam logic [4:0] ST_WRAL  = 5'h11;
  localparam logic [4:0] ST_ERAL  = 5'h12;
  localparam logic [4:0] ST_EWEN  = 5'h13;
  localparam logic [4:0] ST_WRITE = 5'h14;
  localparam logic [4:0] ST_READ  = 5'h18;
  localparam logic [4:0] ST_ERASE = 5'h1C;

  // Pin register bit positions.
  localparam int PIN_CS  = 7;
  localparam int PIN_CLK = 6;
  localparam int PIN_DI  = 1;
  localparam int PIN_DO  = 0;

  // Register numbers and bus operations.
  localparam logic [3:0] REG_TILT_X_HI = 4'h3;
  localparam logic [3:0] REG_TILT_Y_HI = 4'h5;
  localparam logic [3:0] REG_ZERO      = 4'h6;
  localparam logic [3:0] REG_PIN       = 4'h8;
  localparam logic       OP_READ       = 1'b0;
  localparam logic       OP_WRITE      = 1'b1;

  // Register read values.
  localparam logic [7:0] RD_OPEN = 8'hFF;
  localparam logic [7:0] RD_TILT = 8'h07;
  localparam logic [7:0] RD_ZERO = 8'h00;

  // Protocol counts.
  localparam logic [4:0]        CMD_BITS  = 5'd10;
  localparam logic [4:0]        DATA_BITS = 5'd16;
  localparam logic [WORD_W-1:0] ERASED    = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic exec;     // apply the request and load the result register
    logic load;     // move the fetched word into the shift register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_needed;  // the request starts a READ and needs the word fetched
  } stat_t;

  // Opcode and address bits 7..6 select the next protocol state.
  function automatic logic [4:0] decode_cmd(logic [3:0] bits);
    logic [4:0] s;
    s = {1'b1, bits};
    if (bits[3:2] != 2'b00) begin
      s[1:0] = 2'b00;
    end
    return s;
  endfunction

  // Fold the 7-bit word address onto the store depth.
  function automatic logic [ADDR_W-1:0] word_index(logic [6:0] wa);
    logic [7:0] w;
    w = {1'b0, wa};
    if (w >= 8'(EEPROM_WORDS)) begin
      w = w - 8'(EEPROM_WORDS);
    end
    return w[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[sv/mwe_ctrl.sv]
// Request sequencer for the Microwire EEPROM pin interface.
// Depends on mwe_pkg for the command and status structs.
`default_nettype none

module mwe_ctrl
  import mwe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // Commands and next state.
  always_comb begin
    state_next  = state;
    in_ready    = (state == S_IDLE);
    cmd.capture = in_valid && (state == S_IDLE);
    cmd.exec    = (state == S_EXEC) && (!out_valid || out_ready);
    cmd.load    = (state == S_LOAD);
    case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.exec) begin
          state_next = stat.load_needed ? S_LOAD : S_IDLE;
        end
      end
      S_LOAD: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The result register holds its request until the consumer takes it.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

[sv/mwe_datapath.sv]
// Datapath: pin register, Microwire protocol registers, word store and result register.
// Depends on mwe_pkg for constants and helpers; driven by mwe_ctrl commands.
`default_nettype none

module mwe_datapath
  import mwe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  output stat_t           stat,
  input  wire logic       op,
  input  wire logic [3:0] reg_select,
  input  wire logic [7:0] data,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  output logic [7:0]      read_data
);

  // Latched request.
  logic       op_q;
  logic [3:0] sel_q;
  logic [7:0] data_q;

  // Architectural state.
  logic              enable;
  logic [7:0]        pin_register;
  logic [4:0]        protocol_state;
  logic [WORD_W-1:0] shift_reg;
  logic [4:0]        bit_count;
  logic [6:0]        word_address;
  logic              write_enabled;

  // Word store; an entry not written since the last fill reads as fill_value.
  logic [WORD_W-1:0]       mem [EEPROM_WORDS];
  logic [EEPROM_WORDS-1:0] valid;
  logic [WORD_W-1:0]       fill_value;
  logic [WORD_W-1:0]       mem_q;
  logic                    valid_q;

  // Next values from the pin write.
  logic [7:0]        v;
  logic [4:0]        protocol_state_next;
  logic [WORD_W-1:0] shift_reg_next;
  logic [4:0]        bit_count_next;
  logic [6:0]        word_address_next;
  logic              write_enabled_next;
  logic              mem_wr;
  logic [WORD_W-1:0] mem_wdata;
  logic              fill;
  logic [WORD_W-1:0] fill_data;
  logic              load_req;
  logic              pin_wr;
  logic [ADDR_W-1:0] idx;
  logic [7:0]        reg_value;

  assign pin_wr           = (op_q == OP_WRITE) && enable && (sel_q == REG_PIN);
  assign idx              = word_index(word_address_next);
  assign stat.load_needed = pin_wr && load_req;

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      sel_q  <= reg_select;
      data_q <= data;
    end
  end

  // Effect of one pin register write on the protocol machine.
  always_comb begin
    v                   = data_q;
    v[PIN_DO]           = 1'b1;
    protocol_state_next = protocol_state;
    shift_reg_next      = shift_reg;
    bit_count_next      = bit_count;
    word_address_next   = word_address;
    write_enabled_next  = write_enabled;
    mem_wr              = 1'b0;
    mem_wdata           = shift_reg;
    fill                = 1'b0;
    fill_data           = shift_reg;
    load_req            = 1'b0;

    // A rising chip select restarts the protocol.
    if (!pin_register[PIN_CS] && v[PIN_CS]) begin
      protocol_state_next = ST_IDLE;
    end

    if (!pin_register[PIN_CLK] && v[PIN_CLK]) begin
      // Shift DI in while a command or write data is arriving.
      if (protocol_state_next inside {ST_CMD, ST_WRITE, ST_WRAL}) begin
        shift_reg_next = {shift_reg_next[WORD_W-2:0], v[PIN_DI]};
        bit_count_next = bit_count_next + 5'd1;
      end

      // Bit handling for the current phase.
      case (protocol_state_next)
        ST_IDLE: begin
          if (v[PIN_DI]) begin
            protocol_state_next = ST_CMD;
            bit_count_next      = '0;
            shift_reg_next      = '0;
          end
        end
        ST_CMD: begin
          if (bit_count_next == CMD_BITS) begin
            protocol_state_next = decode_cmd(shift_reg_next[9:6]);
            bit_count_next      = '0;
            word_address_next   = shift_reg_next[6:0];
          end
        end
        ST_DOUT: begin
          v[PIN_DO]      = shift_reg_next[WORD_W-1];
          shift_reg_next = {shift_reg_next[WORD_W-2:0], 1'b0};
          bit_count_next = bit_count_next - 5'd1;
          if (bit_count_next == 5'd0) begin
            protocol_state_next = ST_IDLE;
          end
        end
        default: begin
        end
      endcase

      // Command execution, possibly on the same clock edge as the decode.
      case (protocol_state_next)
        ST_EWEN: begin
          write_enabled_next  = 1'b1;
          protocol_state_next = ST_IDLE;
        end
        ST_EWDS: begin
          write_enabled_next  = 1'b0;
          protocol_state_next = ST_IDLE;
        end
        ST_WRITE: begin
          if (bit_count_next == DATA_BITS) begin
            mem_wr              = write_enabled_next;
            mem_wdata           = shift_reg_next;
            protocol_state_next = ST_IDLE;
          end
        end
        ST_ERASE: begin
          mem_wr              = write_enabled_next;
          mem_wdata           = ERASED;
          protocol_state_next = ST_IDLE;
        end
        ST_READ: begin
          bit_count_next      = DATA_BITS;
          load_req            = 1'b1;
          protocol_state_next = ST_DOUT;
          v[PIN_DO]           = 1'b0;
        end
        ST_WRAL: begin
          if (bit_count_next == DATA_BITS) begin
            fill                = write_enabled_next;
            fill_data           = shift_reg_next;
            protocol_state_next = ST_IDLE;
          end
        end
        ST_ERAL: begin
          fill                = write_enabled_next;
          fill_data           = ERASED;
          protocol_state_next = ST_IDLE;
        end
        default: begin
        end
      endcase
    end else if (v[PIN_CS] && pin_register[PIN_CLK] && !v[PIN_CLK]) begin
      // A falling clock under chip select holds DO.
      v[PIN_DO] = pin_register[PIN_DO];
    end
  end

  // Register window read.
  always_comb begin
    case (sel_q)
      REG_TILT_X_HI, REG_TILT_Y_HI: reg_value = RD_TILT;
      REG_ZERO:                     reg_value = RD_ZERO;
      REG_PIN:                      reg_value = pin_register;
      default:                      reg_value = RD_OPEN;
    endcase
    if (!enable) begin
      reg_value = RD_OPEN;
    end
  end

  // Protocol registers, configuration and entry valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      pin_register   <= '0;
      protocol_state <= ST_IDLE;
      shift_reg      <= '0;
      bit_count      <= '0;
      word_address   <= '0;
      write_enabled  <= 1'b0;
      valid          <= '0;
      fill_value     <= ERASED;
    end else begin
      if (cfg_wr_en) begin
        enable <= cfg_wr_data;
      end
      if (cmd.exec && pin_wr) begin
        pin_register   <= v;
        protocol_state <= protocol_state_next;
        shift_reg      <= shift_reg_next;
        bit_count      <= bit_count_next;
        word_address   <= word_address_next;
        write_enabled  <= write_enabled_next;
        if (fill) begin
          valid      <= '0;
          fill_value <= fill_data;
        end else if (mem_wr) begin
          valid[idx] <= 1'b1;
        end
      end
      if (cmd.load) begin
        shift_reg <= valid_q ? mem_q : fill_value;
      end
    end
  end

  // Word store with registered read port.
  always_ff @(posedge clk) begin
    if (cmd.exec && pin_wr && mem_wr) begin
      mem[idx] <= mem_wdata;
    end
    mem_q   <= mem[idx];
    valid_q <= valid[idx];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (op_q == OP_READ) begin
        read_data <= reg_value;
      end else if (pin_wr) begin
        read_data <= v;
      end else begin
        read_data <= pin_register;
      end
    end
  end

endmodule

`default_nettype wire

[sv/microwire_eeprom_pin_interface_unit.sv]
// Top level of the Microwire EEPROM pin interface: controller plus datapath.
// Depends on mwe_pkg, mwe_ctrl and mwe_datapath.
//
// A CPU-side register window in front of a bit-banged Microwire serial EEPROM of
// 128 words of 16 bits. Each request (a register read or write) is captured on
// acceptance and its result is registered in the execute step that follows, which
// waits while an earlier result still sits in the output register; a pin write that
// starts a READ command adds a load step while the addressed word comes through
// the registered read port of the store. One request is in flight at a time, so the
// block takes no new request until the last one has passed capture, execute and, for
// a READ, load. WRAL and ERAL complete in one request: a row of entry valid bits is
// cleared and the fill word is kept in a register, so no clearing pass runs after
// reset or after a fill. The enable register is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while no request is pending; the block does not enforce it.
`default_nettype none

module microwire_eeprom_pin_interface_unit
  import mwe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       op,
  input  wire logic [3:0] reg_select,
  input  wire logic [7:0] data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      read_data,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data
);

  cmd_t  cmd;
  stat_t stat;

  mwe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mwe_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .op          (op),
    .reg_select  (reg_select),
    .data        (data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .read_data   (read_data)
  );

  // A request in flight blocks the next one.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in flight");

  // A word load only follows the execute step of the same request.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> $past(cmd.exec))
    else $error("store word loaded without a preceding execute");

  // A new result appears only from an execute step.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.exec))
    else $error("result presented without an execute step");

endmodule

`default_nettype wire

[verif/mwe_readback_check.sv]
// Read-back checker for the Microwire EEPROM pin interface: watches the request, result
// and enable-register ports, predicts every read_data value and compares it in order.
// Depends on mwe_pkg for register numbers, pin bit positions and protocol state codes.
module mwe_readback_check
  import mwe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       op,
  input  logic [3:0] reg_select,
  input  logic [7:0] data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] read_data,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  output int         mismatches,
  output int         outstanding,
  output int         results_checked
);

  // Predicted copy of the register window and the serial EEPROM behind it.
  logic              window_en;
  logic [7:0]        pins;
  logic [4:0]        proto;
  logic [WORD_W-1:0] shifter;
  logic [4:0]        nbits;
  logic [6:0]        word_addr;
  logic              prog_en;
  logic [WORD_W-1:0] word_store [EEPROM_WORDS];
  logic [7:0]        expected_read_data [$];
  logic [7:0]        want;

  // Apply one pin register write to the predicted EEPROM.
  task automatic step_pins(input logic [7:0] wr);
    logic [7:0] prev;
    logic [7:0] nxt;
    logic [4:0] decoded;
    prev = pins;
    nxt = wr;
    nxt[PIN_DO] = 1'b1;
    // A rising chip select restarts the command decoder.
    if (!prev[PIN_CS] && nxt[PIN_CS]) begin
      proto = ST_IDLE;
    end
    if (!prev[PIN_CLK] && nxt[PIN_CLK]) begin
      if (proto == ST_CMD || proto == ST_WRITE || proto == ST_WRAL) begin
        shifter = {shifter[WORD_W-2:0], nxt[PIN_DI]};
        nbits = nbits + 5'd1;
      end
      // Start bit, command decode and data output on the rising clock.
      case (proto)
        ST_IDLE: begin
          if (nxt[PIN_DI]) begin
            proto = ST_CMD;
            nbits = '0;
            shifter = '0;
          end
        end
        ST_CMD: begin
          if (nbits == CMD_BITS) begin
            decoded = {1'b1, shifter[9:6]};
            if (decoded[3:2] != 2'b00) begin
              decoded[1:0] = 2'b00;
            end
            proto = decoded;
            nbits = '0;
            word_addr = shifter[6:0];
          end
        end
        ST_DOUT: begin
          nxt[PIN_DO] = shifter[WORD_W-1];
          shifter = shifter << 1;
          nbits = nbits - 5'd1;
          if (nbits == '0) begin
            proto = ST_IDLE;
          end
        end
        default: ;
      endcase
      // Commands that act as soon as they are decoded or their data is complete.
      case (proto)
        ST_EWEN: begin
          prog_en = 1'b1;
          proto = ST_IDLE;
        end
        ST_EWDS: begin
          prog_en = 1'b0;
          proto = ST_IDLE;
        end
        ST_WRITE: begin
          if (nbits == DATA_BITS) begin
            if (prog_en) begin
              word_store[int'(word_addr) % EEPROM_WORDS] = shifter;
            end
            proto = ST_IDLE;
          end
        end
        ST_ERASE: begin
          if (prog_en) begin
            word_store[int'(word_addr) % EEPROM_WORDS] = '1;
          end
          proto = ST_IDLE;
        end
        ST_READ: begin
          nbits = DATA_BITS;
          shifter = word_store[int'(word_addr) % EEPROM_WORDS];
          proto = ST_DOUT;
          nxt[PIN_DO] = 1'b0;
        end
        ST_WRAL: begin
          if (nbits == DATA_BITS) begin
            if (prog_en) begin
              foreach (word_store[w]) word_store[w] = shifter;
            end
            proto = ST_IDLE;
          end
        end
        ST_ERAL: begin
          if (prog_en) begin
            foreach (word_store[w]) word_store[w] = '1;
          end
          proto = ST_IDLE;
        end
        default: ;
      endcase
    end else if (nxt[PIN_CS] && prev[PIN_CLK] && !nxt[PIN_CLK]) begin
      // A falling clock under chip select holds DO.
      nxt[PIN_DO] = prev[PIN_DO];
    end
    pins = nxt;
  endtask

  // Value returned by a register read.
  function automatic logic [7:0] window_read(input logic [3:0] sel);
    if (!window_en) begin
      return RD_OPEN;
    end
    case (sel)
      REG_TILT_X_HI, REG_TILT_Y_HI: return RD_TILT;
      REG_ZERO: return RD_ZERO;
      REG_PIN: return pins;
      default: return RD_OPEN;
    endcase
  endfunction

  // Track requests and results at each clock edge.
  always @(posedge clk) begin
    if (rst) begin
      window_en = 1'b0;
      pins = '0;
      proto = ST_IDLE;
      shifter = '0;
      nbits = '0;
      word_addr = '0;
      prog_en = 1'b0;
      foreach (word_store[w]) word_store[w] = ERASED;
      expected_read_data.delete();
      mismatches = 0;
      results_checked = 0;
    end else begin
      if (cfg_wr_en) begin
        window_en = cfg_wr_data;
      end
      // A result always belongs to an earlier request, so compare it first.
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_read_data.size() == 0) begin
          if (mismatches < 10) begin
            $display("result read_data=%02h arrived with no request outstanding", read_data);
          end
          mismatches++;
        end else begin
          want = expected_read_data.pop_front();
          if (read_data !== want) begin
            if (mismatches < 10) begin
              $display("result %0d: read_data expected %02h, got %02h",
                       results_checked, want, read_data);
            end
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (op == OP_WRITE) begin
          if (window_en && reg_select == REG_PIN) begin
            step_pins(data);
          end
          expected_read_data.push_back(pins);
        end else begin
          expected_read_data.push_back(window_read(reg_select));
        end
      end
    end
    outstanding = expected_read_data.size();
  end

endmodule

[verif/microwire_eeprom_pin_interface_unit_test.sv]
// Top of the Microwire EEPROM pin interface test: clock, reset, request and result
// stimulus, enable register writes and the verdict.
// Depends on mwe_pkg, the microwire_eeprom_pin_interface_unit RTL and mwe_readback_check.
module microwire_eeprom_pin_interface_unit_test;
  import mwe_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RESET_CYCLES   = 7;

  // Microwire opcodes, and address bits 7..6 for the opcode-00 group.
  localparam logic [1:0] MW_MISC  = 2'b00;
  localparam logic [1:0] MW_WRITE = 2'b01;
  localparam logic [1:0] MW_READ  = 2'b10;
  localparam logic [1:0] MW_ERASE = 2'b11;
  localparam logic [1:0] SUB_EWDS = 2'b00;
  localparam logic [1:0] SUB_WRAL = 2'b01;
  localparam logic [1:0] SUB_ERAL = 2'b10;
  localparam logic [1:0] SUB_EWEN = 2'b11;

  typedef enum int {
    EE_EWEN, EE_WRITE, EE_READ, EE_ERASE, EE_WRAL, EE_ERAL, EE_EWDS
  } mw_cmd_e;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       op;
  logic [3:0] reg_select;
  logic [7:0] data;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] read_data;
  logic       cfg_wr_en;
  logic       cfg_wr_data;

  int mismatches;
  int outstanding;
  int results_checked;
  int stuck_cycles = 0;
  int requests_sent = 0;
  int enable_writes = 0;
  int cmd_seen [7] = '{default: 0};
  bit source_gaps = 1'b0;
  bit sink_stalls = 1'b0;

  always #5 clk = ~clk;

  microwire_eeprom_pin_interface_unit DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .reg_select(reg_select),
    .data(data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  mwe_readback_check readback (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .reg_select(reg_select),
    .data(data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .results_checked(results_checked)
  );

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic bus_access(input logic rw, input logic [3:0] sel, input logic [7:0] wdata);
    int idle;
    in_valid <= 1'b1;
    op <= rw;
    reg_select <= sel;
    data <= wdata;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
    if (source_gaps) begin
      idle = gap_len();
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
  endtask

  // Hold off new requests until every predicted result has come back.
  task automatic wait_all_returned();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the enable register while the block is idle.
  task automatic write_enable(input logic value);
    wait_all_returned();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    enable_writes++;
  endtask

  // One pin register write with random filler in the unused bits and DO,
  // sometimes followed by a read of the pin register.
  task automatic drive_pins(input logic cs, input logic sck, input logic di);
    logic [7:0] pinval;
    pinval = 8'($urandom);
    pinval[PIN_CS] = cs;
    pinval[PIN_CLK] = sck;
    pinval[PIN_DI] = di;
    bus_access(OP_WRITE, REG_PIN, pinval);
    if ($urandom_range(9, 0) == 0) begin
      bus_access(OP_READ, REG_PIN, 8'($urandom));
    end
  endtask

  task automatic clock_bit(input logic cs, input logic di);
    drive_pins(cs, 1'b0, di);
    drive_pins(cs, 1'b1, di);
  endtask

  // Select, start bit, opcode, address, then the data phase if the command has one.
  task automatic mw_command(input logic [1:0] opc, input logic [7:0] addr,
                            input logic [15:0] word, input logic cs);
    int i;
    drive_pins(1'b0, 1'b0, 1'b0);
    if (cs) begin
      drive_pins(1'b1, 1'b0, 1'b0);
    end
    clock_bit(cs, 1'b1);
    for (i = 1; i >= 0; i--) clock_bit(cs, opc[i]);
    for (i = 7; i >= 0; i--) clock_bit(cs, addr[i]);
    if (opc == MW_WRITE || (opc == MW_MISC && addr[7:6] == SUB_WRAL)) begin
      for (i = 15; i >= 0; i--) clock_bit(cs, word[i]);
    end else if (opc == MW_READ) begin
      // The dummy zero is already on DO; clock out the 16 data bits.
      for (i = 0; i < 16; i++) clock_bit(cs, 1'($urandom));
    end
    drive_pins(1'b0, 1'b0, 1'b0);
  endtask

  // Well-formed command of the given kind with a random address and data word.
  task automatic run_command(input mw_cmd_e kind, input logic cs);
    logic [7:0]  addr;
    logic [15:0] word;
    logic [1:0]  opc;
    addr = 8'($urandom);
    // Keep to a few words at either end often, so reads find earlier writes.
    case ($urandom_range(3, 0))
      0: addr[6:0] = 7'($urandom_range(5, 0));
      1: addr[6:0] = 7'h7F - 7'($urandom_range(2, 0));
      default: ;
    endcase
    word = 16'($urandom);
    if ($urandom_range(7, 0) == 0) begin
      word = $urandom_range(1, 0) ? 16'h0000 : 16'hFFFF;
    end
    opc = MW_MISC;
    case (kind)
      EE_READ:  opc = MW_READ;
      EE_WRITE: opc = MW_WRITE;
      EE_ERASE: opc = MW_ERASE;
      EE_EWEN:  addr[7:6] = SUB_EWEN;
      EE_EWDS:  addr[7:6] = SUB_EWDS;
      EE_WRAL:  addr[7:6] = SUB_WRAL;
      EE_ERAL:  addr[7:6] = SUB_ERAL;
      default: ;
    endcase
    mw_command(opc, addr, word, cs);
    cmd_seen[kind]++;
  endtask

  function automatic mw_cmd_e pick_command();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 30) return EE_READ;
    if (pick < 55) return EE_WRITE;
    if (pick < 67) return EE_EWEN;
    if (pick < 77) return EE_ERASE;
    if (pick < 84) return EE_EWDS;
    if (pick < 92) return EE_WRAL;
    return EE_ERAL;
  endfunction

  // A command cut short, leaving chip select either dropped or still high.
  task automatic broken_command();
    int nclk;
    int i;
    drive_pins(1'b0, 1'b0, 1'b0);
    drive_pins(1'b1, 1'b0, 1'b0);
    clock_bit(1'b1, 1'b1);
    nclk = $urandom_range(25, 0);
    for (i = 0; i < nclk; i++) clock_bit(1'b1, 1'($urandom));
    if ($urandom_range(1, 0)) begin
      drive_pins(1'b0, 1'b0, 1'b0);
    end
  endtask

  // A burst of arbitrary pin register bytes.
  task automatic pin_noise();
    int n;
    int i;
    n = $urandom_range(6, 1);
    for (i = 0; i < n; i++) bus_access(OP_WRITE, REG_PIN, 8'($urandom));
  endtask

  // Result side: mostly ready, with random stalls while stalls are switched on.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(3, 0) == 0) begin
        out_ready <= 1'b0;
        repeat (1 + gap_len()) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // End the run when no request or result has moved for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("no request or result moved for %0d cycles", stuck_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Main sequence: reset, directed requests, then random phases.
  initial begin
    int i;
    int k;
    int phase;
    int target;
    int pick;
    logic window_on;
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= OP_READ;
    reg_select <= '0;
    data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // With the window locked, writes are dropped and reads are open.
    bus_access(OP_READ, REG_PIN, 8'h00);
    bus_access(OP_WRITE, REG_PIN, 8'hFF);
    write_enable(1'b1);
    // Every register number: tilt, zero, pin, latch and unused ones.
    for (i = 0; i < 16; i++) bus_access(OP_READ, 4'(i), 8'hFF);
    // Latch and unused registers ignore writes.
    bus_access(OP_WRITE, 4'h0, 8'hFF);
    bus_access(OP_WRITE, 4'h1, 8'hFF);
    bus_access(OP_WRITE, 4'hF, 8'h00);
    // DO cannot be written; a clock edge with chip select low still acts;
    // a falling clock under chip select holds DO.
    bus_access(OP_WRITE, REG_PIN, 8'h00);
    bus_access(OP_WRITE, REG_PIN, 8'h42);
    bus_access(OP_WRITE, REG_PIN, 8'hBE);
    bus_access(OP_WRITE, REG_PIN, 8'h00);

    for (phase = 0; phase < 8; phase++) begin
      window_on = (phase % 4 != 3);
      write_enable(window_on);
      source_gaps = (phase % 3 != 0);
      sink_stalls = (phase % 3 != 1);
      target = requests_sent + (window_on ? 120 : 30);
      // The first phase walks through every command once, enable first.
      if (phase == 0) begin
        for (k = 0; k < 7; k++) run_command(mw_cmd_e'(k), 1'b1);
      end
      while (requests_sent < target) begin
        pick = $urandom_range(19, 0);
        if (pick < 12) begin
          run_command(pick_command(), $urandom_range(15, 0) != 0);
        end else if (pick < 15) begin
          bus_access(1'($urandom), 4'($urandom), 8'($urandom));
        end else if (pick < 17) begin
          pin_noise();
        end else if (pick < 19) begin
          broken_command();
        end else begin
          wait_all_returned();
        end
      end
    end

    wait_all_returned();
    $display("Sent %0d requests, checked %0d results, %0d enable writes, %0d mismatches.",
             requests_sent, results_checked, enable_writes, mismatches);
    $display("Commands: EWEN %0d WRITE %0d READ %0d ERASE %0d WRAL %0d ERAL %0d EWDS %0d.",
             cmd_seen[EE_EWEN], cmd_seen[EE_WRITE], cmd_seen[EE_READ], cmd_seen[EE_ERASE],
             cmd_seen[EE_WRAL], cmd_seen[EE_ERAL], cmd_seen[EE_EWDS]);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
sv/mwe_pkg.sv
sv/mwe_ctrl.sv
sv/mwe_datapath.sv
sv/microwire_eeprom_pin_interface_unit.sv
verif/mwe_readback_check.sv
verif/microwire_eeprom_pin_interface_unit_test.sv
